// ===== sv/sdcr_pkg.sv =====
// ----------------------------------------------------------------------------
// sdcr_pkg: shared types and constants for the stereo dead-channel repair
// Verdict codes, configuration register indexes, reset values of the
// configuration registers and the per-lane control bundle.
// ----------------------------------------------------------------------------
package sdcr_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CFG_W    = 16;

  // Channel verdict as shown on channel_status
  typedef enum logic [2:0] {
    VERDICT_UNDECIDED = 3'd0,
    VERDICT_NONE      = 3'd1,
    VERDICT_LEFT      = 3'd2,
    VERDICT_RIGHT     = 3'd3,
    VERDICT_BOTH      = 3'd4
  } verdict_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_DEV_THRESH   = 2'd0,
    REG_COUNT_THRESH = 2'd1,
    REG_WARMUP       = 2'd2,
    REG_MONO_BYPASS  = 2'd3
  } cfg_reg_e;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] DEV_THRESH_RST   = 16'd50;
  localparam logic [CFG_W-1:0] COUNT_THRESH_RST = 16'd20;
  localparam logic [CFG_W-1:0] WARMUP_RST       = 16'd2205;

  // Per-frame control for one channel lane
  typedef struct packed {
    logic count; // frame belongs to the check buffer
    logic load;  // buffer start: reload reference, clear hits
  } lane_ctrl_t;

endpackage

// ===== sv/sdcr_lane.sv =====
// ----------------------------------------------------------------------------
// sdcr_lane: activity detector for one audio channel
// Holds the reference sample and a saturating hit counter. Reports whether
// the channel counts as live after the current frame.
// ----------------------------------------------------------------------------
module sdcr_lane
  import sdcr_pkg::*;
#(
  parameter int unsigned HIT_COUNT_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lane_ctrl_t          ctrl_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [CFG_W-1:0]    dev_thresh_i,
  input  logic [CFG_W-1:0]    count_thresh_i,
  output logic                live_o
);

  localparam int unsigned CMP_W = (HIT_COUNT_WIDTH > CFG_W) ? HIT_COUNT_WIDTH : CFG_W;

  logic [SAMPLE_W-1:0]        ref_q, ref_d;
  logic [HIT_COUNT_WIDTH-1:0] hits_q, hits_d;
  logic [HIT_COUNT_WIDTH-1:0] hits_base;
  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]          mag_full;
  logic                       hit;

  // Reference for this frame: a buffer start compares against itself
  assign ref_d = ctrl_i.load ? sample_i : ref_q;

  // Distance from the reference, 17-bit signed, magnitude fits 16 bits
  assign diff     = $signed({sample_i[SAMPLE_W-1], sample_i}) -
                    $signed({ref_d[SAMPLE_W-1], ref_d});
  assign mag_full = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
  assign hit      = (mag_full[SAMPLE_W-1:0] >= dev_thresh_i);

  // Saturating hit counter
  assign hits_base = ctrl_i.load ? '0 : hits_q;
  always_comb begin
    hits_d = hits_base;
    if (hit && (hits_base != {HIT_COUNT_WIDTH{1'b1}})) begin
      hits_d = hits_base + 1'b1;
    end
  end

  assign live_o = (CMP_W'(hits_d) > CMP_W'(count_thresh_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q  <= '0;
      hits_q <= '0;
    end else if (ctrl_i.count) begin
      ref_q  <= ref_d;
      hits_q <= hits_d;
    end
  end

endmodule

// ===== sv/sdcr_merge.sv =====
// ----------------------------------------------------------------------------
// sdcr_merge: combines the lane findings
// Forms the new verdict from the two live flags and repairs a frame by the
// verdict held before it: the live channel is copied over the dead one.
// ----------------------------------------------------------------------------
module sdcr_merge
  import sdcr_pkg::*;
(
  input  verdict_e            held_i,
  input  logic                left_live_i,
  input  logic                right_live_i,
  input  logic [SAMPLE_W-1:0] left_i,
  input  logic [SAMPLE_W-1:0] right_i,
  output verdict_e            decided_o,
  output logic [SAMPLE_W-1:0] left_o,
  output logic [SAMPLE_W-1:0] right_o
);

  // Verdict from the live flags
  always_comb begin
    case ({right_live_i, left_live_i})
      2'b01:   decided_o = VERDICT_LEFT;
      2'b10:   decided_o = VERDICT_RIGHT;
      2'b11:   decided_o = VERDICT_BOTH;
      default: decided_o = VERDICT_NONE;
    endcase
  end

  // Repair by the held verdict
  always_comb begin
    left_o  = left_i;
    right_o = right_i;
    case (held_i)
      VERDICT_LEFT:  right_o = left_i;
      VERDICT_RIGHT: left_o  = right_i;
      default: ;
    endcase
  end

endmodule

// ===== sv/stereo_dead_channel_repair.sv =====
// ----------------------------------------------------------------------------
// stereo_dead_channel_repair: stereo dead-channel detection and repair
// Result of an accepted input request is on the output register in the next
// cycle. Throughput: one frame per cycle while the master side takes results,
// set by the single output register that parts the slave and master sides.
// Reset: asynchronous, active low; verdict undecided, counters cleared,
// configuration registers back to their defaults. No clearing pass.
// ----------------------------------------------------------------------------
module stereo_dead_channel_repair
  import sdcr_pkg::*;
#(
  parameter int unsigned HIT_COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [15:0] left_sample, [31:16] right_sample
  input  logic        s_axis_tuser,  // [0] first_of_buffer
  input  logic        s_axis_tlast,  // last_of_buffer
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // [15:0] left_out, [31:16] right_out,
                                     // [34:32] channel_status, [39:35] zero
);

  // Configuration registers
  logic [CFG_W-1:0] dev_thresh_q, count_thresh_q, warmup_q;
  logic             mono_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_thresh_q   <= DEV_THRESH_RST;
      count_thresh_q <= COUNT_THRESH_RST;
      warmup_q       <= WARMUP_RST;
      mono_q         <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_DEV_THRESH:   dev_thresh_q   <= cfg_data_i;
        REG_COUNT_THRESH: count_thresh_q <= cfg_data_i;
        REG_WARMUP:       warmup_q       <= cfg_data_i;
        REG_MONO_BYPASS:  mono_q         <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Handshake
  logic out_valid_q, out_valid_d;
  logic accept;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  logic [SAMPLE_W-1:0] left_in, right_in;
  assign left_in  = s_axis_tdata[15:0];
  assign right_in = s_axis_tdata[31:16];

  // Check control
  logic [CFG_W-1:0] warm_q, warm_d;
  logic             checking_q, checking_d;
  verdict_e         verdict_q, verdict_d, decided;
  logic             undecided, start, active;
  lane_ctrl_t       lane_ctrl;
  logic             left_live, right_live;

  assign undecided = accept && !mono_q && (verdict_q == VERDICT_UNDECIDED);
  assign start     = undecided && s_axis_tuser && (checking_q || (warm_q >= warmup_q));
  assign active    = undecided && (start || checking_q);

  assign lane_ctrl.load  = start;
  assign lane_ctrl.count = active;

  always_comb begin
    warm_d     = warm_q;
    checking_d = checking_q;
    verdict_d  = verdict_q;
    if (active) begin
      checking_d = !s_axis_tlast;
      if (s_axis_tlast) begin
        verdict_d = decided;
      end
    end else if (undecided && (warm_q != {CFG_W{1'b1}})) begin
      warm_d = warm_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q     <= '0;
      checking_q <= 1'b0;
      verdict_q  <= VERDICT_UNDECIDED;
    end else begin
      warm_q     <= warm_d;
      checking_q <= checking_d;
      verdict_q  <= verdict_d;
    end
  end

  // Channel lanes
  sdcr_lane #(
    .HIT_COUNT_WIDTH (HIT_COUNT_WIDTH)
  ) u_lane_left (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (lane_ctrl),
    .sample_i       (left_in),
    .dev_thresh_i   (dev_thresh_q),
    .count_thresh_i (count_thresh_q),
    .live_o         (left_live)
  );

  sdcr_lane #(
    .HIT_COUNT_WIDTH (HIT_COUNT_WIDTH)
  ) u_lane_right (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (lane_ctrl),
    .sample_i       (right_in),
    .dev_thresh_i   (dev_thresh_q),
    .count_thresh_i (count_thresh_q),
    .live_o         (right_live)
  );

  // Merge and repair
  logic [SAMPLE_W-1:0] left_rep, right_rep;
  verdict_e            held;

  assign held = mono_q ? VERDICT_UNDECIDED : verdict_q;

  sdcr_merge u_merge (
    .held_i       (held),
    .left_live_i  (left_live),
    .right_live_i (right_live),
    .left_i       (left_in),
    .right_i      (right_in),
    .decided_o    (decided),
    .left_o       (left_rep),
    .right_o      (right_rep)
  );

  // Output register
  logic [SAMPLE_W-1:0] left_out_q, right_out_q;
  verdict_e            status_q;

  assign out_valid_d = accept ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      left_out_q  <= left_rep;
      right_out_q <= right_rep;
      status_q    <= verdict_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, status_q, right_out_q, left_out_q};

  // Assertions
  a_verdict_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (verdict_q != VERDICT_UNDECIDED) |=> (verdict_q == $past(verdict_q)))
    else $error("verdict changed after being decided");

  a_check_undecided: assert property (@(posedge clk_i) disable iff (!rst_ni)
    checking_q |-> (verdict_q == VERDICT_UNDECIDED))
    else $error("check running with a verdict already fixed");

  a_warm_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (verdict_q != VERDICT_UNDECIDED) |=> $stable(warm_q))
    else $error("warm-up counter moved after the verdict");

  a_repair_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !mono_q && (verdict_q == VERDICT_LEFT)) |=> (right_out_q == left_out_q))
    else $error("left-only verdict did not copy left over right");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for stereo_dead_channel_repair
// Streams stereo frames through the block with random idling on both sides
// and compares every result against an in-bench model of the warm-up, the
// one-time channel check, the sticky verdict and the repair. Covers sample
// extremes, mono pass-through, the warm-up gate on buffer starts, check
// restarts, the check buffer shapes and long randomized repair traffic under
// several register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import sdcr_pkg::*;

  localparam int HITS_W         = 16;
  localparam int IDLE_PCT       = 12;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    verdict_e    status;
  } repaired_frame_t;

  typedef enum {SHAPE_SINGLE, SHAPE_SHORT, SHAPE_LONG} check_shape_e;

  // DUT inputs, all driven to known values from time zero
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  cfg_reg_e    cfg_index_i   = REG_DEV_THRESH;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  // Shared bench state
  bit          quiet = 1'b0;         // no idling on either side
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  repaired_frame_t expected_frames[$];

  // Model copy of the configuration
  logic [15:0] dev_thr  = DEV_THRESH_RST;
  logic [15:0] cnt_thr  = COUNT_THRESH_RST;
  logic [15:0] warm_thr = WARMUP_RST;
  logic        mono_on  = 1'b0;

  // Model copy of the detector state
  logic [15:0]       warm_cnt   = '0;
  logic              check_open = 1'b0;
  logic [15:0]       anchor_l   = '0;
  logic [15:0]       anchor_r   = '0;
  logic [HITS_W-1:0] hits_l     = '0;
  logic [HITS_W-1:0] hits_r     = '0;
  verdict_e          verdict_q  = VERDICT_UNDECIDED;

  stereo_dead_channel_repair #(
    .HIT_COUNT_WIDTH(HITS_W)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Model of the block
  // ---------------------------------------------------------------------------

  // Distance from the anchor sample reaches the deviation threshold
  function automatic bit deviates(logic [15:0] s, logic [15:0] anchor);
    int d;
    d = int'($signed(s)) - int'($signed(anchor));
    if (d < 0) d = -d;
    return d >= int'(dev_thr);
  endfunction

  function automatic logic [HITS_W-1:0] bump_hits(logic [HITS_W-1:0] h);
    return (h == '1) ? h : h + 1'b1;
  endfunction

  // Advance the model by one accepted frame and queue its result
  task automatic predict_repair(logic [15:0] l, logic [15:0] r, logic first, logic last);
    repaired_frame_t res;
    verdict_e        held;
    res.left  = l;
    res.right = r;
    if (!mono_on) begin
      held = verdict_q;
      // repair uses the verdict held before this frame
      if (held == VERDICT_LEFT) res.right = l;
      else if (held == VERDICT_RIGHT) res.left = r;
      if (held == VERDICT_UNDECIDED) begin
        // buffer start opens (or restarts) the check
        if (first && (check_open || warm_cnt >= warm_thr)) begin
          check_open = 1'b1;
          anchor_l   = l;
          anchor_r   = r;
          hits_l     = '0;
          hits_r     = '0;
        end
        if (check_open) begin
          if (deviates(l, anchor_l)) hits_l = bump_hits(hits_l);
          if (deviates(r, anchor_r)) hits_r = bump_hits(hits_r);
          if (last) begin
            case ({hits_l > cnt_thr, hits_r > cnt_thr})
              2'b10:   verdict_q = VERDICT_LEFT;
              2'b01:   verdict_q = VERDICT_RIGHT;
              2'b11:   verdict_q = VERDICT_BOTH;
              default: verdict_q = VERDICT_NONE;
            endcase
            check_open = 1'b0;
          end
        end else if (warm_cnt != 16'hFFFF) begin
          warm_cnt++;
        end
      end
    end
    res.status = verdict_q;
    expected_frames.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One register write request; valid stays high for a following write
  task automatic put_reg(cfg_reg_e idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_DEV_THRESH:   dev_thr  = data;
      REG_COUNT_THRESH: cnt_thr  = data;
      REG_WARMUP:       warm_thr = data;
      REG_MONO_BYPASS:  mono_on  = data[0];
      default: ;
    endcase
  endtask

  // Write all four registers; only called while the block is idle
  task automatic program_regs(logic [15:0] dev, logic [15:0] cnt, logic [15:0] warm,
                              logic mono);
    put_reg(REG_DEV_THRESH, dev);
    put_reg(REG_COUNT_THRESH, cnt);
    put_reg(REG_WARMUP, warm);
    put_reg(REG_MONO_BYPASS, {15'd0, mono});
    cfg_valid_i <= 1'b0;
  endtask

  // Send one frame request; tvalid is left high for back-to-back frames
  task automatic send_frame(logic [15:0] l, logic [15:0] r, logic first, logic last);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r, l};
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_repair(l, r, first, last);
  endtask

  // Stop sending and let every pending result drain out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] any_sample();
    case ($urandom_range(15))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_noise_frame(bit allow_first);
    send_frame(any_sample(), any_sample(), allow_first && ($urandom_range(7) == 0),
               $urandom_range(7) == 0);
  endtask

  // Sample that is a hit against the anchor; anchor is 0x8000 for large thresholds
  function automatic logic [15:0] far_sample(logic [15:0] anchor);
    int step;
    if (dev_thr > 16'd16000) return 16'h7FFF;
    step = int'(dev_thr) + int'($urandom_range(15000));
    return 16'(int'($signed(anchor)) + ($urandom_range(1) ? step : -step));
  endfunction

  // Sample that stays inside the deviation window around the anchor
  function automatic logic [15:0] near_sample(logic [15:0] anchor);
    int span;
    int v;
    if (dev_thr == 16'd0) return 16'($urandom);
    span = (dev_thr > 16'd1000) ? 1000 : int'(dev_thr) - 1;
    v = int'($signed(anchor)) + ($urandom_range(1) ? 1 : -1) * int'($urandom_range(span));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults: extremes and marks while still in warm-up, stray end marks
  task automatic test_directed_extremes();
    send_frame(16'h8000, 16'h7FFF, 1'b1, 1'b0);
    send_frame(16'h7FFF, 16'h8000, 1'b0, 1'b0);
    send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b1);
    send_frame(16'hFFFF, 16'h0000, 1'b1, 1'b1);
    send_frame(16'h8000, 16'h8000, 1'b0, 1'b0);
    send_frame(16'h7FFF, 16'h7FFF, 1'b0, 1'b1);
    send_frame(16'h0001, 16'hFFFE, 1'b1, 1'b0);
    send_frame(16'h5555, 16'hAAAA, 1'b0, 1'b0);
    send_frame(16'hAAAA, 16'h5555, 1'b0, 1'b1);
  endtask

  // Mono: pass-through, no state change even on buffer marks
  task automatic test_mono_bypass();
    wait_idle();
    program_regs(DEV_THRESH_RST, COUNT_THRESH_RST, 16'h0000, 1'b1);
    send_frame(16'h1234, 16'hEDCB, 1'b1, 1'b0);
    send_frame(16'h8000, 16'h7FFF, 1'b0, 1'b0);
    send_frame(16'h7FFF, 16'h8000, 1'b1, 1'b1);
    send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b1);
    send_frame(16'hFFFF, 16'h0000, 1'b1, 1'b0);
    send_frame(16'h5A5A, 16'hA5A5, 1'b0, 1'b1);
  endtask

  // Warm-up gate: buffer starts short of the count open nothing, and a count
  // reached mid-buffer opens nothing without a start mark
  task automatic test_warmup_gate();
    wait_idle();
    program_regs(DEV_THRESH_RST, COUNT_THRESH_RST, warm_cnt + 16'd60, 1'b0);
    while (warm_cnt < warm_thr) send_noise_frame(1'b1);
    repeat (12) send_noise_frame(1'b0);
  endtask

  // The one check of the run: aborted starts, then a shaped check buffer
  task automatic test_check_buffer();
    check_shape_e shape;
    logic [15:0]  dev;
    logic [15:0]  cnt;
    logic [15:0]  base_l;
    logic [15:0]  base_r;
    bit           live_l;
    bit           live_r;
    int           len;
    wait_idle();
    case ($urandom_range(5))
      0:       shape = SHAPE_SINGLE;
      1:       shape = SHAPE_LONG;
      default: shape = SHAPE_SHORT;
    endcase
    case ($urandom_range(7))
      0:       dev = 16'h0000;
      1:       dev = 16'hFFFF;
      default: dev = 16'($urandom_range(1, 200));
    endcase
    // with dev nonzero live gets len-1 hits, dead none; cnt splits them if len > 1
    case (shape)
      SHAPE_SINGLE: begin
        len = 1;
        cnt = 16'($urandom_range(1));
      end
      SHAPE_LONG: begin
        len = $urandom_range(60, 120);
        cnt = 16'(len - 2);     // live channel clears it by one hit
      end
      default: begin
        len = $urandom_range(2, 40);
        cnt = 16'($urandom_range(0, len - 2));
      end
    endcase
    // warm-up either off or exactly met by the frames counted so far
    program_regs(dev, cnt, $urandom_range(1) ? 16'h0000 : warm_cnt, 1'b0);
    live_l = $urandom_range(1);
    live_r = $urandom_range(1);

    // buffer starts that get restarted before they end
    repeat ($urandom_range(0, 3)) begin
      send_frame(any_sample(), any_sample(), 1'b1, 1'b0);
      repeat ($urandom_range(0, 6)) send_frame(any_sample(), any_sample(), 1'b0, 1'b0);
    end

    base_l = (live_l && dev > 16'd16000) ? 16'h8000
                                         : 16'(int'($urandom_range(0, 32000)) - 16000);
    base_r = (live_r && dev > 16'd16000) ? 16'h8000
                                         : 16'(int'($urandom_range(0, 32000)) - 16000);
    send_frame(base_l, base_r, 1'b1, len == 1);
    for (int i = 1; i < len; i++) begin
      send_frame(live_l ? far_sample(base_l) : near_sample(base_l),
                 live_r ? far_sample(base_r) : near_sample(base_r),
                 1'b0, i == len - 1);
    end
  endtask

  // Repair traffic under several register settings, verdict already fixed
  task automatic test_repair_random();
    int n;
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      quiet <= (phase == 0);
      case (phase)
        2:       program_regs(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
        3:       program_regs(16'h0000, 16'hFFFF, 16'h0000, 1'b0);
        4:       program_regs(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
        default: program_regs(16'($urandom), 16'($urandom), 16'($urandom),
                              1'($urandom_range(1)));
      endcase
      n = (phase == 0) ? 200 : 150;
      for (int i = 0; i < n; i++) begin
        // sender holds off until the block has emptied
        if (phase == 1 && i == 90) wait_idle();
        send_noise_frame(1'b1);
      end
    end
    quiet <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and receiver back-pressure
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    repaired_frame_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_frames.size() == 0) begin
        $error("result with no frame pending: tdata %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_frames.pop_front();
        if (m_axis_tdata[15:0] !== want.left) begin
          $error("left_out: expected %h, got %h", want.left, m_axis_tdata[15:0]);
          mismatches++;
        end
        if (m_axis_tdata[31:16] !== want.right) begin
          $error("right_out: expected %h, got %h", want.right, m_axis_tdata[31:16]);
          mismatches++;
        end
        if (m_axis_tdata[34:32] !== want.status) begin
          $error("channel_status: expected %0d, got %0d", want.status, m_axis_tdata[34:32]);
          mismatches++;
        end
        if (m_axis_tdata[39:35] !== 5'd0) begin
          $error("tdata padding: expected %h, got %h", 5'd0, m_axis_tdata[39:35]);
          mismatches++;
        end
      end
    end
    m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog: cycles without any accepted request
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_mono_bypass();
    test_warmup_gate();
    test_check_buffer();
    test_repair_random();
    wait_idle();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
